>>> sv/ps2_scancode_to_ascii_assert.svh
// ----------------------------------------------------------------------------
// PS/2 scancode translator assertion macros
// Shared property forms for the concurrent checks of the translator.
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_ASCII_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_ASSERT_SVH

// same-cycle implication
`define PS2SC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2 scancode translator check failed");

// next-cycle implication
`define PS2SC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2 scancode translator check failed");

`endif

>>> sv/ps2sc_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 scancode translator package
// Code kinds, prefix states, modifier bundle and set-2 lookup tables.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

   // classification of one received byte
   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_MAKE   = 3'd1,
      KIND_BREAK  = 3'd2,
      KIND_XMAKE  = 3'd3,
      KIND_XBREAK = 3'd4,
      KIND_FAKE   = 3'd5,
      KIND_PAUSE  = 3'd6
   } kind_type;

   // prefix sequence states
   typedef enum logic [7:0] {
      ST_START   = 8'b0000_0001,
      ST_BRK     = 8'b0000_0010,
      ST_EXT     = 8'b0000_0100,
      ST_EXT_BRK = 8'b0000_1000,
      ST_PA      = 8'b0001_0000,
      ST_PB      = 8'b0010_0000,
      ST_PC      = 8'b0100_0000,
      ST_PD      = 8'b1000_0000
   } pfx_state_type;

   // modifier and lock state after the current word's update
   typedef struct packed {
      logic       shift;
      logic       ctrl;
      logic       alt;
      logic       del;
      logic [2:0] locks;   // bit0 scroll, bit1 num, bit2 caps
   } mods_type;

   // lock bit positions
   localparam int LOCK_SCROLL = 0;
   localparam int LOCK_NUM    = 1;
   localparam int LOCK_CAPS   = 2;

   // prefix and special scan codes
   localparam logic [7:0] SC_BREAK   = 8'hF0;
   localparam logic [7:0] SC_EXT     = 8'hE0;
   localparam logic [7:0] SC_PAUSE   = 8'hE1;
   localparam logic [7:0] SC_CTRL    = 8'h14;
   localparam logic [7:0] SC_NUMLK   = 8'h77;
   localparam logic [7:0] SC_LSHIFT  = 8'h12;
   localparam logic [7:0] SC_RSHIFT  = 8'h59;
   localparam logic [7:0] SC_ALT     = 8'h11;
   localparam logic [7:0] SC_ENTER   = 8'h5A;
   localparam logic [7:0] SC_DELETE  = 8'h71;
   localparam logic [7:0] SC_BKSP    = 8'h66;
   localparam logic [7:0] SC_CAPSLK  = 8'h58;
   localparam logic [7:0] SC_SCRLK   = 8'h7E;
   localparam logic [7:0] SC_ESC     = 8'h76;
   localparam logic [7:0] SC_KP_MUL  = 8'h7C;
   localparam logic [7:0] SC_KP_SUB  = 8'h7B;
   localparam logic [7:0] SC_KP_ADD  = 8'h79;
   localparam logic [7:0] SC_KP_DIV  = 8'h4A;
   localparam logic [7:0] SC_TAB     = 8'h0D;

   // ASCII codes used directly
   localparam logic [6:0] CH_BS    = 7'h08;
   localparam logic [6:0] CH_TAB   = 7'h09;
   localparam logic [6:0] CH_LF    = 7'h0A;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_ESC   = 7'h1B;
   localparam logic [6:0] CH_STAR  = 7'h2A;
   localparam logic [6:0] CH_PLUS  = 7'h2B;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [6:0] CH_SLASH = 7'h2F;
   localparam logic [6:0] CH_UPPER = 7'h41;
   localparam logic [6:0] CH_LOWER = 7'h61;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } alpha_hit_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } ctlx_hit_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] ch;
   } pad_hit_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] lo;
      logic [6:0] hi;
   } sym_hit_type;

   // letter keys, index 0 = 'a'
   function automatic alpha_hit_type alpha_lookup(input logic [7:0] b);
      alpha_hit_type r;
      r.hit = 1'b1;
      unique case (b)
         8'h1C: r.idx = 5'd0;   8'h32: r.idx = 5'd1;   8'h21: r.idx = 5'd2;
         8'h23: r.idx = 5'd3;   8'h24: r.idx = 5'd4;   8'h2B: r.idx = 5'd5;
         8'h34: r.idx = 5'd6;   8'h33: r.idx = 5'd7;   8'h43: r.idx = 5'd8;
         8'h3B: r.idx = 5'd9;   8'h42: r.idx = 5'd10;  8'h4B: r.idx = 5'd11;
         8'h3A: r.idx = 5'd12;  8'h31: r.idx = 5'd13;  8'h44: r.idx = 5'd14;
         8'h4D: r.idx = 5'd15;  8'h15: r.idx = 5'd16;  8'h2D: r.idx = 5'd17;
         8'h1B: r.idx = 5'd18;  8'h2C: r.idx = 5'd19;  8'h3C: r.idx = 5'd20;
         8'h2A: r.idx = 5'd21;  8'h1D: r.idx = 5'd22;  8'h22: r.idx = 5'd23;
         8'h35: r.idx = 5'd24;  8'h1A: r.idx = 5'd25;
         default: begin
            r.hit = 1'b0;
            r.idx = 5'd0;
         end
      endcase
      return r;
   endfunction

   // extra ctrl characters 0x1B..0x1F
   function automatic ctlx_hit_type ctlx_lookup(input logic [7:0] b);
      ctlx_hit_type r;
      r.hit = 1'b1;
      unique case (b)
         8'h54: r.idx = 3'd0;
         8'h5D: r.idx = 3'd1;
         8'h5B: r.idx = 3'd2;
         8'h36: r.idx = 3'd3;
         8'h4E: r.idx = 3'd4;
         default: begin
            r.hit = 1'b0;
            r.idx = 3'd0;
         end
      endcase
      return r;
   endfunction

   // keypad digits and point under num lock
   function automatic pad_hit_type pad_lookup(input logic [7:0] b);
      pad_hit_type r;
      r.hit = 1'b1;
      unique case (b)
         8'h70: r.ch = 7'h30;  8'h69: r.ch = 7'h31;  8'h72: r.ch = 7'h32;
         8'h7A: r.ch = 7'h33;  8'h6B: r.ch = 7'h34;  8'h73: r.ch = 7'h35;
         8'h74: r.ch = 7'h36;  8'h6C: r.ch = 7'h37;  8'h75: r.ch = 7'h38;
         8'h7D: r.ch = 7'h39;  8'h71: r.ch = 7'h2E;
         default: begin
            r.hit = 1'b0;
            r.ch  = 7'h00;
         end
      endcase
      return r;
   endfunction

   // digit row and punctuation: unshifted, shifted
   function automatic sym_hit_type sym_lookup(input logic [7:0] b);
      sym_hit_type r;
      r.hit = 1'b1;
      unique case (b)
         8'h0E: begin r.lo = 7'h60; r.hi = 7'h7E; end
         8'h16: begin r.lo = 7'h31; r.hi = 7'h21; end
         8'h1E: begin r.lo = 7'h32; r.hi = 7'h40; end
         8'h26: begin r.lo = 7'h33; r.hi = 7'h23; end
         8'h25: begin r.lo = 7'h34; r.hi = 7'h24; end
         8'h2E: begin r.lo = 7'h35; r.hi = 7'h25; end
         8'h36: begin r.lo = 7'h36; r.hi = 7'h5E; end
         8'h3D: begin r.lo = 7'h37; r.hi = 7'h26; end
         8'h3E: begin r.lo = 7'h38; r.hi = 7'h2A; end
         8'h46: begin r.lo = 7'h39; r.hi = 7'h28; end
         8'h45: begin r.lo = 7'h30; r.hi = 7'h29; end
         8'h4E: begin r.lo = 7'h2D; r.hi = 7'h5F; end
         8'h55: begin r.lo = 7'h3D; r.hi = 7'h2B; end
         8'h54: begin r.lo = 7'h5B; r.hi = 7'h7B; end
         8'h5B: begin r.lo = 7'h5D; r.hi = 7'h7D; end
         8'h5D: begin r.lo = 7'h5C; r.hi = 7'h7C; end
         8'h4C: begin r.lo = 7'h3B; r.hi = 7'h3A; end
         8'h52: begin r.lo = 7'h27; r.hi = 7'h22; end
         8'h41: begin r.lo = 7'h2C; r.hi = 7'h3C; end
         8'h49: begin r.lo = 7'h2E; r.hi = 7'h3E; end
         8'h4A: begin r.lo = 7'h2F; r.hi = 7'h3F; end
         8'h29: begin r.lo = 7'h20; r.hi = 7'h20; end
         default: begin
            r.hit = 1'b0;
            r.lo  = 7'h00;
            r.hi  = 7'h00;
         end
      endcase
      return r;
   endfunction

endpackage

>>> sv/ps2_scancode_to_ascii.sv
// ----------------------------------------------------------------------------
// PS/2 set-2 scancode to ASCII translator
// Structure: two registers; a word taken on req_ is held in the input register,
// then moved into the result register and presented on rsp_ once that frees.
// Throughput: one word per cycle while rsp_ready allows; prefix/modifier update
// and the translation tables sit between the input and result registers. With
// rsp_ready low the two registers hold two words, then req_ready drops.
// Reset: synchronous; clears the prefix machine, modifiers, locks and valids.
// ----------------------------------------------------------------------------
`include "ps2_scancode_to_ascii_assert.svh"

module ps2_scancode_to_ascii import ps2sc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_code_kind,
   output logic [7:0] rsp_key_code,
   output logic [6:0] rsp_ascii_char,
   output logic       rsp_shift_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_alt_held,
   output logic [2:0] rsp_lock_lights,
   output logic       rsp_reset_request
);

   logic       in_vld_ff;
   logic [7:0] in_code_ff;
   logic       out_vld_ff;
   logic       fire;

   kind_type   kind;
   mods_type   mods;
   logic [6:0] ascii;
   logic       rst_req;

   logic [2:0] kind_ff;
   logic [7:0] code_ff;
   logic [6:0] ascii_ff;
   mods_type   mods_ff;
   logic       rst_req_ff;

   // stage handshake: input word moves on when the result register frees
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) in_vld_ff <= req_valid;
         if (fire) out_vld_ff <= 1'b1;
         else if (rsp_ready) out_vld_ff <= 1'b0;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_code_ff <= req_scan_code;
   end

   ps2sc_state u_state (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .scan_code (in_code_ff),
      .kind      (kind),
      .mods      (mods)
   );

   ps2sc_xlate u_xlate (
      .scan_code     (in_code_ff),
      .kind          (kind),
      .mods          (mods),
      .ascii_char    (ascii),
      .reset_request (rst_req)
   );

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff    <= kind;
         code_ff    <= in_code_ff;
         ascii_ff   <= ascii;
         mods_ff    <= mods;
         rst_req_ff <= rst_req;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_code_kind     = kind_ff;
   assign rsp_key_code      = code_ff;
   assign rsp_ascii_char    = ascii_ff;
   assign rsp_shift_held    = mods_ff.shift;
   assign rsp_ctrl_held     = mods_ff.ctrl;
   assign rsp_alt_held      = mods_ff.alt;
   assign rsp_lock_lights   = mods_ff.locks;
   assign rsp_reset_request = rst_req_ff;

   // checks
   `PS2SC_ASSERT_IMP(a_ascii_only_make, clock, reset,
      rsp_valid && (rsp_ascii_char != 7'h00),
      (rsp_code_kind == KIND_MAKE) || (rsp_code_kind == KIND_XMAKE))
   `PS2SC_ASSERT_IMP(a_rst_req_mods, clock, reset,
      rsp_valid && rsp_reset_request, rsp_ctrl_held && rsp_alt_held)
   `PS2SC_ASSERT_NXT(a_pending_moves, clock, reset,
      in_vld_ff && !out_vld_ff, rsp_valid)

endmodule

>>> sv/ps2sc_state.sv
// ----------------------------------------------------------------------------
// PS/2 prefix machine and modifier tracker
// Classifies each word and holds shift, ctrl, alt, delete and lock state.
// ----------------------------------------------------------------------------
module ps2sc_state import ps2sc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] scan_code,
   output kind_type   kind,
   output mods_type   mods
);

   pfx_state_type pst_ff, pst_in;
   logic [1:0]    shift_ff, shift_in;
   logic [1:0]    ctrl_ff, ctrl_in;
   logic [1:0]    alt_ff, alt_in;
   logic          del_ff, del_in;
   logic [2:0]    lock_ff, lock_in;

   logic is_fake;
   assign is_fake = (scan_code == SC_LSHIFT) || (scan_code == SC_RSHIFT);

   // prefix sequence decode
   always_comb begin
      pst_in = pst_ff;
      kind   = KIND_NONE;
      unique case (pst_ff)
         ST_START: begin
            if (scan_code == SC_BREAK)      pst_in = ST_BRK;
            else if (scan_code == SC_EXT)   pst_in = ST_EXT;
            else if (scan_code == SC_PAUSE) pst_in = ST_PA;
            else                            kind   = KIND_MAKE;
         end
         ST_BRK: begin
            pst_in = ST_START;
            kind   = KIND_BREAK;
         end
         ST_EXT: begin
            if (scan_code == SC_BREAK) begin
               pst_in = ST_EXT_BRK;
            end else begin
               pst_in = ST_START;
               kind   = is_fake ? KIND_FAKE : KIND_XMAKE;
            end
         end
         ST_EXT_BRK: begin
            pst_in = ST_START;
            kind   = is_fake ? KIND_FAKE : KIND_XBREAK;
         end
         ST_PA: begin
            if (scan_code == SC_CTRL)       pst_in = ST_PB;
            else if (scan_code == SC_BREAK) pst_in = ST_PD;
            else                            pst_in = ST_START;
         end
         ST_PB: begin
            if (scan_code == SC_NUMLK)      pst_in = ST_PC;
            else if (scan_code == SC_BREAK) pst_in = ST_PD;
            else                            pst_in = ST_START;
         end
         ST_PC: begin
            pst_in = (scan_code == SC_PAUSE) ? ST_PA : ST_START;
         end
         ST_PD: begin
            if (scan_code == SC_CTRL) begin
               pst_in = ST_PB;
            end else begin
               pst_in = ST_START;
               if (scan_code == SC_NUMLK) kind = KIND_PAUSE;
            end
         end
         default: pst_in = ST_START;
      endcase
   end

   // modifier and lock update; bit0 right, bit1 left
   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      del_in   = del_ff;
      lock_in  = lock_ff;
      case (kind)
         KIND_XMAKE: begin
            if (scan_code == SC_CTRL)        ctrl_in[0] = 1'b1;
            else if (scan_code == SC_ALT)    alt_in[0]  = 1'b1;
            else if (scan_code == SC_DELETE) del_in     = 1'b1;
         end
         KIND_XBREAK: begin
            if (scan_code == SC_CTRL)        ctrl_in[0] = 1'b0;
            else if (scan_code == SC_ALT)    alt_in[0]  = 1'b0;
            else if (scan_code == SC_DELETE) del_in     = 1'b0;
         end
         KIND_MAKE: begin
            case (scan_code)
               SC_RSHIFT: shift_in[0] = 1'b1;
               SC_LSHIFT: shift_in[1] = 1'b1;
               SC_CTRL:   ctrl_in[1]  = 1'b1;
               SC_ALT:    alt_in[1]   = 1'b1;
               SC_NUMLK:  lock_in[LOCK_NUM]    = ~lock_ff[LOCK_NUM];
               SC_CAPSLK: lock_in[LOCK_CAPS]   = ~lock_ff[LOCK_CAPS];
               SC_SCRLK:  lock_in[LOCK_SCROLL] = ~lock_ff[LOCK_SCROLL];
               default: ;
            endcase
         end
         KIND_BREAK: begin
            case (scan_code)
               SC_RSHIFT: shift_in[0] = 1'b0;
               SC_LSHIFT: shift_in[1] = 1'b0;
               SC_CTRL:   ctrl_in[1]  = 1'b0;
               SC_ALT:    alt_in[1]   = 1'b0;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // state after this word's update
   assign mods.shift = |shift_in;
   assign mods.ctrl  = |ctrl_in;
   assign mods.alt   = |alt_in;
   assign mods.del   = del_in;
   assign mods.locks = lock_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff   <= ST_START;
         shift_ff <= 2'b00;
         ctrl_ff  <= 2'b00;
         alt_ff   <= 2'b00;
         del_ff   <= 1'b0;
         lock_ff  <= 3'b000;
      end else if (fire) begin
         pst_ff   <= pst_in;
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         del_ff   <= del_in;
         lock_ff  <= lock_in;
      end
   end

endmodule

>>> sv/ps2sc_xlate.sv
// ----------------------------------------------------------------------------
// PS/2 scancode to ASCII translation
// Maps a make code to a character from the updated modifier state.
// ----------------------------------------------------------------------------
module ps2sc_xlate import ps2sc_pkg::*; (
   input  logic [7:0] scan_code,
   input  kind_type   kind,
   input  mods_type   mods,
   output logic [6:0] ascii_char,
   output logic       reset_request
);

   alpha_hit_type alpha;
   ctlx_hit_type  ctlx;
   pad_hit_type   pad;
   sym_hit_type   sym;
   logic          is_make, is_xmake, letter_up;

   assign alpha     = alpha_lookup(scan_code);
   assign ctlx      = ctlx_lookup(scan_code);
   assign pad       = pad_lookup(scan_code);
   assign sym       = sym_lookup(scan_code);
   assign is_make   = (kind == KIND_MAKE);
   assign is_xmake  = (kind == KIND_XMAKE);
   assign letter_up = mods.shift ^ mods.locks[LOCK_CAPS];

   // priority chain of the translation rules
   always_comb begin
      ascii_char    = 7'h00;
      reset_request = 1'b0;
      if (!is_make && !is_xmake) begin
         ascii_char = 7'h00;
      end else if (is_xmake && !mods.alt && !mods.ctrl) begin
         // plain extended keys
         if (scan_code == SC_DELETE)      ascii_char = CH_BS;
         else if (scan_code == SC_KP_DIV) ascii_char = CH_SLASH;
         else if (scan_code == SC_ENTER)  ascii_char = CH_CR;
      end else if (scan_code == SC_ENTER) begin
         ascii_char = mods.ctrl ? CH_LF : CH_CR;
      end else if (scan_code == SC_ESC) begin
         ascii_char = CH_ESC;
      end else if (scan_code == SC_KP_MUL) begin
         ascii_char = CH_STAR;
      end else if (scan_code == SC_KP_SUB) begin
         ascii_char = CH_MINUS;
      end else if (scan_code == SC_KP_ADD) begin
         ascii_char = CH_PLUS;
      end else if (scan_code == SC_BKSP) begin
         ascii_char = CH_BS;
      end else if (mods.ctrl && alpha.hit) begin
         ascii_char = {2'b00, alpha.idx} + 7'd1;
      end else if (mods.ctrl && ctlx.hit) begin
         ascii_char = CH_ESC + {4'b0000, ctlx.idx};
      end else begin
         // ctrl+alt+delete: raised here, translation goes on
         reset_request = mods.ctrl && mods.alt && mods.del;
         if (mods.locks[LOCK_NUM] && pad.hit) begin
            ascii_char = pad.ch;
         end else if (!mods.alt && scan_code == SC_DELETE) begin
            ascii_char = CH_BS;
         end else if (alpha.hit) begin
            ascii_char = (letter_up ? CH_UPPER : CH_LOWER) + {2'b00, alpha.idx};
         end else if (sym.hit) begin
            ascii_char = mods.shift ? sym.hi : sym.lo;
         end else if (scan_code == SC_TAB) begin
            ascii_char = CH_TAB;
         end
      end
   end

endmodule
